>>> rtl/bsr_pkg.sv
// Package of the broadcast sequence reorder receiver.
// Holds sizes, field widths, result and packet codes, register indexes
// and the pointer and handle helpers. Depends on nothing.
package bsr_pkg;

  localparam int WAIT_DEPTH   = 8;
  localparam int HANDLE_COUNT = 256;

  localparam int PTR_W = $clog2(WAIT_DEPTH);
  localparam int CNT_W = $clog2(WAIT_DEPTH + 1);

  localparam int TAG_W  = 8;
  localparam int PKND_W = 2;
  localparam int SEQ_W  = 16;
  localparam int LEN_W  = 12;
  localparam int HND_W  = 8;
  localparam int ADDR_W = 32;
  localparam int PORT_W = 16;
  localparam int ENT_W  = SEQ_W + LEN_W + HND_W;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 88;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_RECEIVE_TAG = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DUP_WINDOW  = CFG_IDX_W'(1);

  localparam logic [SEQ_W-1:0]  DUP_WINDOW_RESET = SEQ_W'(100);
  localparam logic [PKND_W-1:0] PKT_ORIGINAL     = PKND_W'(0);

  typedef enum logic [1:0] {
    RES_COMMIT  = 2'd0,
    RES_REPEAT  = 2'd1,
    RES_DISCARD = 2'd2
  } res_kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_PKT,
    S_READ,
    S_DRAIN
  } state_e;

  typedef logic [255:0][HND_W-1:0] hnd_tbl_t;

  function automatic hnd_tbl_t build_hnd_tbl();
    hnd_tbl_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = HND_W'(i % HANDLE_COUNT);
    end
    return t;
  endfunction

  // handle modulo the buffer count, as a constant lookup
  localparam hnd_tbl_t HND_TBL = build_hnd_tbl();

  function automatic logic [PTR_W-1:0] ptr_bump(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(WAIT_DEPTH - 1)) r = '0;
    else r = p + PTR_W'(1);
    return r;
  endfunction

endpackage

>>> rtl/broadcast_seq_reorder_receiver.sv
// Top level of the broadcast sequence reorder receiver.
// Uses bsr_pkg (sizes, codes, helpers) and bsr_ram (wait queue store).
//
// Usage: each word on the s_axis channel is one received packet
// descriptor; the m_axis channel carries the results it causes (commit,
// repeat request, discard), with tlast on the final result of a packet.
// A packet may cause no result at all (queued behind an outstanding one).
// The cfg channel writes receive_tag (index 0, also clears the expected
// sequence) and duplicate_window (index 1); write it only while idle.
// Timing: a packet is evaluated in the cycle after it is taken; queued
// entries come out of the wait RAM one per cycle after a read setup
// state, as long as the m_axis receiver takes them. The next packet
// is taken while the last result still waits in the output register.
// When the m_axis receiver stalls, the output register and the drain hold.
// Reset clears tag, window (to 100), expected sequence, repair address and
// queue pointers at once; the wait RAM needs no clearing pass.
module broadcast_seq_reorder_receiver (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // packet_tag, sequence_number, payload_length, buffer_handle,
  // sender_address, sender_port, zero pad
  input  logic [bsr_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  // packet_kind
  input  logic [bsr_pkg::PKND_W-1:0]    s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // result_sequence, result_length, result_handle, request_address,
  // request_port, zero pad
  output logic [bsr_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // result_kind
  output logic [1:0]                    m_axis_tuser_o,
  output logic                          m_axis_tlast_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bsr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bsr_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int SEQ_W  = bsr_pkg::SEQ_W;
  localparam int LEN_W  = bsr_pkg::LEN_W;
  localparam int HND_W  = bsr_pkg::HND_W;
  localparam int ADDR_W = bsr_pkg::ADDR_W;
  localparam int PORT_W = bsr_pkg::PORT_W;
  localparam int PTR_W  = bsr_pkg::PTR_W;
  localparam int CNT_W  = bsr_pkg::CNT_W;
  localparam int ENT_W  = bsr_pkg::ENT_W;

  bsr_pkg::state_e state_q, state_d;

  logic [bsr_pkg::TAG_W-1:0] tag_q, tag_d;
  logic [SEQ_W-1:0]          dw_q, dw_d;
  logic [SEQ_W-1:0]          exp_q, exp_d;
  logic [ADDR_W-1:0]         rep_addr_q, rep_addr_d;
  logic [PORT_W-1:0]         rep_port_q, rep_port_d;
  logic [PTR_W-1:0]          rd_q, rd_d, wr_q, wr_d;
  logic [CNT_W-1:0]          count_q, count_d;
  logic                      out_valid_q, out_valid_d;
  logic                      drain_after_q, drain_after_d;
  logic                      pkt_after_q, pkt_after_d;
  bsr_pkg::res_kind_e        res_kind_q, res_kind_d;
  bsr_pkg::res_kind_e        drain_kind_q, drain_kind_d;

  // captured packet
  logic [bsr_pkg::TAG_W-1:0]  p_tag_q;
  logic [bsr_pkg::PKND_W-1:0] p_kind_q;
  logic [SEQ_W-1:0]           p_seq_q;
  logic [LEN_W-1:0]           p_len_q;
  logic [HND_W-1:0]           p_hnd_q;
  logic [ADDR_W-1:0]          p_addr_q;
  logic [PORT_W-1:0]          p_port_q;

  // output register payload
  logic [1:0]        o_kind_q, o_kind_d;
  logic [SEQ_W-1:0]  o_seq_q, o_seq_d;
  logic [LEN_W-1:0]  o_len_q, o_len_d;
  logic [HND_W-1:0]  o_hnd_q, o_hnd_d;
  logic [ADDR_W-1:0] o_addr_q, o_addr_d;
  logic [PORT_W-1:0] o_port_q, o_port_d;
  logic              o_last_q, o_last_d;
  logic              out_load;

  logic             ram_we, ram_re;
  logic [PTR_W-1:0] ram_raddr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;

  logic             in_acc, out_free, tag_ok, behind, ahead, dup, jump;
  logic             commit_now, full, q_empty;
  logic [SEQ_W-1:0] diff_b, gap, exp_eff;
  logic [SEQ_W-1:0] e_seq;
  logic [LEN_W-1:0] e_len;
  logic [HND_W-1:0] e_hnd;

  assign s_axis_tready_o = (state_q == bsr_pkg::S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  assign e_seq = ram_rdata[SEQ_W-1:0];
  assign e_len = ram_rdata[SEQ_W +: LEN_W];
  assign e_hnd = ram_rdata[SEQ_W+LEN_W +: HND_W];

  assign ram_wdata = {p_hnd_q, p_len_q, p_seq_q};

  // packet decision terms, from the captured packet
  assign q_empty    = (count_q == '0);
  assign full       = (count_q >= CNT_W'(bsr_pkg::WAIT_DEPTH));
  assign tag_ok     = (p_tag_q == tag_q);
  assign behind     = (p_seq_q < exp_q);
  assign ahead      = (p_seq_q > exp_q);
  assign diff_b     = exp_q - p_seq_q;
  assign gap        = p_seq_q - exp_q;
  assign dup        = behind && (diff_b < dw_q);
  assign jump       = ahead && q_empty && (gap > SEQ_W'(1));
  assign exp_eff    = jump ? p_seq_q : exp_q;
  assign commit_now = (p_seq_q == exp_eff) || (exp_eff == '0);

  bsr_ram #(
    .WIDTH(ENT_W),
    .DEPTH(bsr_pkg::WAIT_DEPTH)
  ) u_wait_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d       = state_q;
    tag_d         = tag_q;
    dw_d          = dw_q;
    exp_d         = exp_q;
    rep_addr_d    = rep_addr_q;
    rep_port_d    = rep_port_q;
    rd_d          = rd_q;
    wr_d          = wr_q;
    count_d       = count_q;
    drain_after_d = drain_after_q;
    pkt_after_d   = pkt_after_q;
    res_kind_d    = res_kind_q;
    drain_kind_d  = drain_kind_q;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = rd_q;
    out_load      = 1'b0;
    o_kind_d      = o_kind_q;
    o_seq_d       = o_seq_q;
    o_len_d       = o_len_q;
    o_hnd_d       = o_hnd_q;
    o_addr_d      = o_addr_q;
    o_port_d      = o_port_q;
    o_last_d      = o_last_q;

    case (state_q)
      bsr_pkg::S_IDLE: begin
        if (in_acc) state_d = bsr_pkg::S_EVAL;
      end
      bsr_pkg::S_EVAL: begin
        drain_after_d = 1'b0;
        pkt_after_d   = 1'b0;
        drain_kind_d  = bsr_pkg::RES_COMMIT;
        res_kind_d    = bsr_pkg::RES_COMMIT;
        // take the repair target from an original, even a late one
        if (tag_ok && p_kind_q == bsr_pkg::PKT_ORIGINAL) begin
          rep_addr_d = p_addr_q;
          rep_port_d = p_port_q;
        end
        if (!tag_ok || dup) begin
          res_kind_d = bsr_pkg::RES_DISCARD;
          state_d    = bsr_pkg::S_PKT;
        end else begin
          if (behind) begin
            // large backward jump: throw the queue away, then commit
            if (q_empty) begin
              state_d = bsr_pkg::S_PKT;
            end else begin
              drain_kind_d = bsr_pkg::RES_DISCARD;
              pkt_after_d  = 1'b1;
              state_d      = bsr_pkg::S_READ;
            end
          end else if (commit_now) begin
            drain_after_d = !q_empty;
            state_d       = bsr_pkg::S_PKT;
          end else if (full) begin
            // oldest entries first, the new packet goes out last
            pkt_after_d = 1'b1;
            state_d     = bsr_pkg::S_READ;
          end else begin
            ram_we  = 1'b1;
            wr_d    = bsr_pkg::ptr_bump(wr_q);
            count_d = count_q + CNT_W'(1);
            if (q_empty) begin
              res_kind_d = bsr_pkg::RES_REPEAT;
              state_d    = bsr_pkg::S_PKT;
            end else begin
              state_d = bsr_pkg::S_IDLE;
            end
          end
        end
      end
      bsr_pkg::S_PKT: begin
        if (out_free) begin
          out_load = 1'b1;
          o_kind_d = res_kind_q;
          o_last_d = !drain_after_q;
          if (res_kind_q == bsr_pkg::RES_REPEAT) begin
            o_seq_d  = exp_q;
            o_len_d  = '0;
            o_hnd_d  = '0;
            o_addr_d = rep_addr_q;
            o_port_d = rep_port_q;
          end else begin
            o_seq_d  = p_seq_q;
            o_len_d  = p_len_q;
            o_hnd_d  = p_hnd_q;
            o_addr_d = '0;
            o_port_d = '0;
          end
          if (res_kind_q == bsr_pkg::RES_COMMIT) exp_d = p_seq_q + SEQ_W'(1);
          pkt_after_d = 1'b0;
          state_d = drain_after_q ? bsr_pkg::S_READ : bsr_pkg::S_IDLE;
        end
      end
      bsr_pkg::S_READ: begin
        ram_re  = 1'b1;
        state_d = bsr_pkg::S_DRAIN;
      end
      bsr_pkg::S_DRAIN: begin
        if (out_free) begin
          out_load = 1'b1;
          o_kind_d = drain_kind_q;
          o_seq_d  = e_seq;
          o_len_d  = e_len;
          o_hnd_d  = e_hnd;
          o_addr_d = '0;
          o_port_d = '0;
          o_last_d = (count_q == CNT_W'(1)) && !pkt_after_q;
          if (drain_kind_q == bsr_pkg::RES_COMMIT) exp_d = e_seq + SEQ_W'(1);
          rd_d    = bsr_pkg::ptr_bump(rd_q);
          count_d = count_q - CNT_W'(1);
          if (count_q > CNT_W'(1)) begin
            // fetch the next entry while this one goes out
            ram_re    = 1'b1;
            ram_raddr = bsr_pkg::ptr_bump(rd_q);
          end else if (pkt_after_q) begin
            drain_after_d = 1'b0;
            state_d       = bsr_pkg::S_PKT;
          end else begin
            state_d = bsr_pkg::S_IDLE;
          end
        end
      end
      default: state_d = bsr_pkg::S_IDLE;
    endcase

    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == bsr_pkg::REG_RECEIVE_TAG) begin
        tag_d = cfg_data_i[bsr_pkg::TAG_W-1:0];
        exp_d = '0;
      end else if (cfg_index_i == bsr_pkg::REG_DUP_WINDOW) begin
        dw_d = cfg_data_i;
      end
    end

    if (out_load) out_valid_d = 1'b1;
    else if (m_axis_tready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= bsr_pkg::S_IDLE;
      tag_q         <= '0;
      dw_q          <= bsr_pkg::DUP_WINDOW_RESET;
      exp_q         <= '0;
      rep_addr_q    <= '0;
      rep_port_q    <= '0;
      rd_q          <= '0;
      wr_q          <= '0;
      count_q       <= '0;
      out_valid_q   <= 1'b0;
      drain_after_q <= 1'b0;
      pkt_after_q   <= 1'b0;
      res_kind_q    <= bsr_pkg::RES_COMMIT;
      drain_kind_q  <= bsr_pkg::RES_COMMIT;
    end else begin
      state_q       <= state_d;
      tag_q         <= tag_d;
      dw_q          <= dw_d;
      exp_q         <= exp_d;
      rep_addr_q    <= rep_addr_d;
      rep_port_q    <= rep_port_d;
      rd_q          <= rd_d;
      wr_q          <= wr_d;
      count_q       <= count_d;
      out_valid_q   <= out_valid_d;
      drain_after_q <= drain_after_d;
      pkt_after_q   <= pkt_after_d;
      res_kind_q    <= res_kind_d;
      drain_kind_q  <= drain_kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p_tag_q  <= s_axis_tdata_i[7:0];
      p_kind_q <= s_axis_tuser_i;
      p_seq_q  <= s_axis_tdata_i[23:8];
      p_len_q  <= s_axis_tdata_i[35:24];
      p_hnd_q  <= bsr_pkg::HND_TBL[s_axis_tdata_i[43:36]];
      p_addr_q <= s_axis_tdata_i[75:44];
      p_port_q <= s_axis_tdata_i[91:76];
    end
    o_kind_q <= o_kind_d;
    o_seq_q  <= o_seq_d;
    o_len_q  <= o_len_d;
    o_hnd_q  <= o_hnd_d;
    o_addr_q <= o_addr_d;
    o_port_q <= o_port_d;
    o_last_q <= o_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = o_kind_q;
  assign m_axis_tlast_o  = o_last_q;
  assign m_axis_tdata_o  = {4'b0, o_port_q, o_addr_q, o_hnd_q, o_len_q, o_seq_q};

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(bsr_pkg::WAIT_DEPTH))
    else $error("wait queue count above depth");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (rd_q == wr_q))
    else $error("empty queue with unequal pointers");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("queue write without count increment");

  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bsr_pkg::S_DRAIN) |-> (count_q != '0))
    else $error("drain from an empty queue");

  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |->
      ($past(state_q) == bsr_pkg::S_PKT || $past(state_q) == bsr_pkg::S_DRAIN))
    else $error("result raised outside an emit state");
`endif

endmodule

>>> rtl/bsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read data holds while no read is issued. No dependencies.
module bsr_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sim/bsr_result_checker.sv
// Result checker for the broadcast sequence reorder receiver testbench.
// Watches the packet, result and register channels, predicts the results of
// each packet and compares them in order. Depends on bsr_pkg.
module bsr_result_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  input  logic                           s_axis_tready_i,
  // packet_tag, sequence_number, payload_length, buffer_handle,
  // sender_address, sender_port, zero pad
  input  logic [bsr_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // packet_kind
  input  logic [bsr_pkg::PKND_W-1:0]     s_axis_tuser_i,
  input  logic                           m_axis_tvalid_i,
  input  logic                           m_axis_tready_i,
  // result_sequence, result_length, result_handle, request_address,
  // request_port, zero pad
  input  logic [bsr_pkg::OUT_DATA_W-1:0] m_axis_tdata_i,
  // result_kind
  input  logic [1:0]                     m_axis_tuser_i,
  input  logic                           m_axis_tlast_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [bsr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bsr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o
);

  localparam int TAG_W  = bsr_pkg::TAG_W;
  localparam int PKND_W = bsr_pkg::PKND_W;
  localparam int SEQ_W  = bsr_pkg::SEQ_W;
  localparam int LEN_W  = bsr_pkg::LEN_W;
  localparam int HND_W  = bsr_pkg::HND_W;
  localparam int ADDR_W = bsr_pkg::ADDR_W;
  localparam int PORT_W = bsr_pkg::PORT_W;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
    logic [HND_W-1:0] hnd;
  } held_pkt_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SEQ_W-1:0]  seq;
    logic [LEN_W-1:0]  len;
    logic [HND_W-1:0]  hnd;
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
    logic              is_last;
  } result_t;

  logic [TAG_W-1:0]  rx_tag;
  logic [SEQ_W-1:0]  dup_window;
  logic [SEQ_W-1:0]  next_seq;
  logic [ADDR_W-1:0] repair_addr;
  logic [PORT_W-1:0] repair_port;
  held_pkt_t         held_q[$];
  result_t           expected_results[$];

  function automatic result_t make_result(input logic [1:0] kind, input held_pkt_t p,
                                          input logic [ADDR_W-1:0] addr,
                                          input logic [PORT_W-1:0] port);
    result_t r;
    r.kind    = kind;
    r.seq     = p.seq;
    r.len     = p.len;
    r.hnd     = p.hnd;
    r.addr    = addr;
    r.port    = port;
    r.is_last = 1'b0;
    return r;
  endfunction

  // Work out the results that one accepted packet causes and queue them.
  function automatic void reorder_packet(input logic [TAG_W-1:0] tag,
                                         input logic [PKND_W-1:0] kind,
                                         input held_pkt_t pkt,
                                         input logic [ADDR_W-1:0] addr,
                                         input logic [PORT_W-1:0] port);
    result_t   run[$];
    held_pkt_t nxt;
    held_pkt_t gap_pkt;
    bit        take;
    take = 1'b0;
    if (tag != rx_tag) begin
      run.push_back(make_result(bsr_pkg::RES_DISCARD, pkt, '0, '0));
    end else begin
      if (kind == bsr_pkg::PKT_ORIGINAL) begin
        repair_addr = addr;
        repair_port = port;
      end
      if (pkt.seq < next_seq && next_seq - pkt.seq < dup_window) begin
        run.push_back(make_result(bsr_pkg::RES_DISCARD, pkt, '0, '0));
      end else begin
        if (pkt.seq < next_seq) begin
          // far behind: throw away everything held and restart the stream
          while (held_q.size() > 0)
            run.push_back(make_result(bsr_pkg::RES_DISCARD, held_q.pop_front(), '0, '0));
          next_seq = '0;
        end else if (pkt.seq > next_seq && held_q.size() == 0 && pkt.seq - next_seq > 1) begin
          next_seq = pkt.seq;
        end
        if (pkt.seq == next_seq || next_seq == '0) begin
          take = 1'b1;
          nxt  = pkt;
        end else if (held_q.size() >= bsr_pkg::WAIT_DEPTH) begin
          // full: force the oldest out and move on
          take = 1'b1;
          nxt  = held_q.pop_front();
          held_q.push_back(pkt);
        end else begin
          if (held_q.size() == 0) begin
            gap_pkt     = '0;
            gap_pkt.seq = next_seq;
            run.push_back(make_result(bsr_pkg::RES_REPEAT, gap_pkt, repair_addr,
                                      repair_port));
          end
          held_q.push_back(pkt);
        end
        if (take) begin
          held_q.push_front(nxt);
          while (held_q.size() > 0) begin
            nxt = held_q.pop_front();
            run.push_back(make_result(bsr_pkg::RES_COMMIT, nxt, '0, '0));
            next_seq = nxt.seq + 1'b1;
          end
        end
      end
    end
    if (run.size() > 0) run[run.size()-1].is_last = 1'b1;
    foreach (run[i]) expected_results.push_back(run[i]);
  endfunction

  function automatic bit field_differs(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t   got;
    result_t   want;
    held_pkt_t pkt;
    bit        bad;
    if (!rst_ni) begin
      rx_tag       = '0;
      dup_window   = bsr_pkg::DUP_WINDOW_RESET;
      next_seq     = '0;
      repair_addr  = '0;
      repair_port  = '0;
      held_q.delete();
      expected_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.kind    = m_axis_tuser_i;
        got.seq     = m_axis_tdata_i[15:0];
        got.len     = m_axis_tdata_i[27:16];
        got.hnd     = m_axis_tdata_i[35:28];
        got.addr    = m_axis_tdata_i[67:36];
        got.port    = m_axis_tdata_i[83:68];
        got.is_last = m_axis_tlast_i;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual kind %0h seq %0h hnd %0h",
                   $time, got.kind, got.seq, got.hnd);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          bad  = field_differs("result_kind", 32'(want.kind), 32'(got.kind))
               | field_differs("result_sequence", 32'(want.seq), 32'(got.seq))
               | field_differs("result_length", 32'(want.len), 32'(got.len))
               | field_differs("result_handle", 32'(want.hnd), 32'(got.hnd))
               | field_differs("request_address", want.addr, got.addr)
               | field_differs("request_port", 32'(want.port), 32'(got.port))
               | field_differs("last_of_run", 32'(want.is_last), 32'(got.is_last));
          if (bad) fail_count_o++;
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        pkt.seq = s_axis_tdata_i[23:8];
        pkt.len = s_axis_tdata_i[35:24];
        pkt.hnd = HND_W'(s_axis_tdata_i[43:36] % bsr_pkg::HANDLE_COUNT);
        reorder_packet(s_axis_tdata_i[7:0], s_axis_tuser_i, pkt,
                       s_axis_tdata_i[75:44], s_axis_tdata_i[91:76]);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == bsr_pkg::REG_RECEIVE_TAG) begin
          rx_tag   = cfg_data_i[TAG_W-1:0];
          next_seq = '0;
        end else if (cfg_index_i == bsr_pkg::REG_DUP_WINDOW) begin
          dup_window = cfg_data_i;
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

>>> sim/broadcast_seq_reorder_receiver_tb.sv
// Testbench top of the broadcast sequence reorder receiver.
// Drives packets, register writes and result back-pressure; checking is
// done by bsr_result_checker. Depends on bsr_pkg and the receiver RTL.
module broadcast_seq_reorder_receiver_tb;

  localparam int TAG_W      = bsr_pkg::TAG_W;
  localparam int PKND_W     = bsr_pkg::PKND_W;
  localparam int SEQ_W      = bsr_pkg::SEQ_W;
  localparam int LEN_W      = bsr_pkg::LEN_W;
  localparam int HND_W      = bsr_pkg::HND_W;
  localparam int ADDR_W     = bsr_pkg::ADDR_W;
  localparam int PORT_W     = bsr_pkg::PORT_W;
  localparam int IN_DATA_W  = bsr_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = bsr_pkg::OUT_DATA_W;
  localparam int CFG_IDX_W  = bsr_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = bsr_pkg::CFG_DATA_W;

  localparam logic [PKND_W-1:0]    KIND_RETRAN = PKND_W'(1);
  localparam logic [PKND_W-1:0]    KIND_REPAIR = PKND_W'(2);
  localparam logic [PKND_W-1:0]    KIND_SPARE  = PKND_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE   = CFG_IDX_W'(2);

  localparam int MAX_IDLE      = 8;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 2 * (bsr_pkg::WAIT_DEPTH + 4);
  localparam int PHASE_ITEMS   = 100;
  localparam int RUN_LIMIT     = 5_000_000;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  s_valid   = 1'b0;
  logic                  s_ready;
  logic [IN_DATA_W-1:0]  s_data    = '0;
  logic [PKND_W-1:0]     s_user    = '0;
  logic                  m_valid;
  logic                  m_ready   = 1'b0;
  logic [OUT_DATA_W-1:0] m_data;
  logic [1:0]            m_user;
  logic                  m_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int unsigned      fail_count;
  int unsigned      pending;
  // long holds asked for by the stimulus and served by the result sink
  int unsigned      hold_asked = 0;
  int unsigned      hold_given = 0;
  bit               send_quiet = 1'b0;
  bit               take_quiet = 1'b0;
  logic [TAG_W-1:0] cur_tag    = '0;
  logic [SEQ_W-1:0] stream_seq = '0;
  logic [SEQ_W-1:0] hole_seq   = '0;
  bit               hole_valid = 1'b0;

  always #10 clk_i = ~clk_i;

  broadcast_seq_reorder_receiver DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user),
    .m_axis_tlast_o (m_last),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  bsr_result_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_i(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_i(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_i (m_data),
    .m_axis_tuser_i (m_user),
    .m_axis_tlast_i (m_last),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin : run_limit
    #RUN_LIMIT;
    $display("FAILED: results differ");
    $finish;
  end

  // Present one packet word after a random gap and hold it until taken.
  task automatic send_packet(input logic [TAG_W-1:0] tag, input logic [PKND_W-1:0] kind,
                             input logic [SEQ_W-1:0] seq, input logic [LEN_W-1:0] len,
                             input logic [HND_W-1:0] hnd, input logic [ADDR_W-1:0] addr,
                             input logic [PORT_W-1:0] port);
    int gap;
    if ($urandom_range(0, 19) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_data  <= {4'b0, port, addr, hnd, len, seq, tag};
    s_user  <= kind;
    s_valid <= 1'b1;
    do @(posedge clk_i); while (!s_ready);
  endtask

  // Mostly a well-formed stream with holes, repairs and late copies; some noise.
  task automatic send_random_packet();
    logic [TAG_W-1:0]  tag;
    logic [PKND_W-1:0] kind;
    logic [SEQ_W-1:0]  seq;
    int                pick;
    tag  = cur_tag;
    kind = PKND_W'($urandom_range(0, 3));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      seq = stream_seq;
      stream_seq++;
    end else if (pick < 60) begin
      hole_seq   = stream_seq;
      hole_valid = 1'b1;
      seq        = stream_seq + 1'b1;
      stream_seq = seq + 1'b1;
    end else if (pick < 72) begin
      if (hole_valid) begin
        seq        = hole_seq;
        kind       = KIND_REPAIR;
        hole_valid = 1'b0;
      end else begin
        seq = stream_seq;
        stream_seq++;
      end
    end else if (pick < 82) begin
      seq = stream_seq - SEQ_W'($urandom_range(1, 120));
    end else if (pick < 87) begin
      tag = cur_tag ^ TAG_W'($urandom_range(1, 255));
      seq = SEQ_W'($urandom());
    end else if (pick < 92) begin
      seq        = stream_seq - SEQ_W'($urandom_range(100, 40000));
      stream_seq = seq + 1'b1;
      hole_valid = 1'b0;
    end else if (pick < 95) begin
      // run up to the wrap point
      seq        = 16'hFFFF - SEQ_W'($urandom_range(0, 3));
      stream_seq = seq + 1'b1;
      hole_valid = 1'b0;
    end else begin
      seq        = SEQ_W'($urandom());
      stream_seq = seq + 1'b1;
      hole_valid = 1'b0;
    end
    send_packet(tag, kind, seq, LEN_W'($urandom_range(0, 4095)), HND_W'($urandom()),
                ADDR_W'($urandom()), PORT_W'($urandom()));
  endtask

  task automatic program_regs(input logic [TAG_W-1:0] tag, input logic [SEQ_W-1:0] window,
                              input bit touch_spare);
    cfg_valid <= 1'b1;
    cfg_index <= bsr_pkg::REG_RECEIVE_TAG;
    cfg_data  <= CFG_DATA_W'(tag);
    do @(posedge clk_i); while (!cfg_ready);
    cfg_index <= bsr_pkg::REG_DUP_WINDOW;
    cfg_data  <= window;
    do @(posedge clk_i); while (!cfg_ready);
    if (touch_spare) begin
      // unknown index: must be ignored
      cfg_index <= REG_SPARE;
      cfg_data  <= CFG_DATA_W'($urandom());
      do @(posedge clk_i); while (!cfg_ready);
    end
    cfg_valid  <= 1'b0;
    cur_tag    = tag;
    stream_seq = SEQ_W'($urandom());
    hole_valid = 1'b0;
  endtask

  // Drop valid, wait for every expected result, then let the block go idle.
  task automatic settle();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input int hold_at);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i == hold_at) hold_asked++;
      send_random_packet();
    end
    settle();
  endtask

  initial begin : result_sink
    int gap;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 19) == 0) take_quiet = !take_quiet;
      if (hold_asked != hold_given) begin
        gap = LONG_HOLD;
        hold_given++;
      end else begin
        gap = take_quiet ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (m_valid !== 1'b1);
    end
  end

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    program_regs(8'h00, bsr_pkg::DUP_WINDOW_RESET, 1'b0);

    // wrong tag, all fields at their top
    send_packet(8'hFF, KIND_SPARE, 16'hFFFF, 12'hFFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
    // expected zero takes anything; original sets the repair address
    send_packet(cur_tag, bsr_pkg::PKT_ORIGINAL, 16'd10, 12'h000, 8'h00, 32'hFFFF_FFFF,
                16'hFFFF);
    send_packet(cur_tag, KIND_RETRAN, 16'd11, 12'd100, 8'd1, 32'h0, 16'h0);
    // late duplicate
    send_packet(cur_tag, KIND_REPAIR, 16'd5, 12'd64, 8'd2, 32'h0, 16'h0);
    // gap with nothing held: jump ahead
    send_packet(cur_tag, bsr_pkg::PKT_ORIGINAL, 16'd14, 12'd7, 8'd3, 32'h0A00_0001,
                16'd5000);
    // one ahead: repeat request, then hold; spare kind behaves like a repair
    send_packet(cur_tag, KIND_REPAIR, 16'd16, 12'd8, 8'd4, 32'h0, 16'h0);
    send_packet(cur_tag, KIND_SPARE, 16'd17, 12'd9, 8'd5, 32'h1234_5678, 16'h4321);
    // the missing one releases the held run
    send_packet(cur_tag, KIND_REPAIR, 16'd15, 12'd10, 8'd6, 32'h0, 16'h0);
    // fill the wait queue, then overflow it
    send_packet(cur_tag, bsr_pkg::PKT_ORIGINAL, 16'd19, 12'd11, 8'd7, 32'hC0A8_0101,
                16'd6000);
    for (int s = 20; s <= 27; s++)
      send_packet(cur_tag, KIND_RETRAN, SEQ_W'(s), LEN_W'($urandom()), HND_W'($urandom()),
                  ADDR_W'($urandom()), PORT_W'($urandom()));
    send_packet(cur_tag, KIND_REPAIR, 16'd1000, 12'd1, 8'd8, 32'h0, 16'h0);
    send_packet(cur_tag, KIND_REPAIR, 16'd1002, 12'd2, 8'd9, 32'h0, 16'h0);
    send_packet(cur_tag, KIND_REPAIR, 16'd1003, 12'd3, 8'd10, 32'h0, 16'h0);
    // large backward jump: flush the held packets and restart
    send_packet(cur_tag, KIND_RETRAN, 16'd200, 12'd4, 8'd11, 32'h0, 16'h0);
    // wrap to zero, then anything is taken
    send_packet(cur_tag, KIND_REPAIR, 16'hFFFF, 12'd5, 8'd12, 32'h0, 16'h0);
    send_packet(cur_tag, KIND_REPAIR, 16'd7, 12'hFFF, 8'hFF, 32'h0, 16'h0);
    send_packet(cur_tag, bsr_pkg::PKT_ORIGINAL, 16'd8, 12'd4088, 8'h80, 32'h0, 16'h0);

    run_phase(40);

    program_regs(8'hFF, 16'hFFFF, 1'b1);
    stream_seq = 16'hFFF0;
    run_phase(-1);

    program_regs(8'h5A, 16'h0001, 1'b0);
    run_phase(-1);

    // zero window: every backward packet restarts the stream
    program_regs(8'hA5, 16'h0000, 1'b1);
    run_phase(60);

    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/bsr_pkg.sv
rtl/bsr_ram.sv
rtl/broadcast_seq_reorder_receiver.sv
sim/bsr_result_checker.sv
sim/broadcast_seq_reorder_receiver_tb.sv
